// ===== sv/inwb_pkg.sv =====
package inwb_pkg;

    // Buffer geometry
    localparam int BUFFER_WORDS = 240;
    localparam int ADDR_W       = 8;
    localparam int WORD_W       = 16;
    localparam int TAIL_START   = 224;
    localparam int ROW_BLOCKS   = 15;

    // Operation codes
    localparam logic [2:0] OP_CLEAR      = 3'd0;
    localparam logic [2:0] OP_FIRE_COLOR = 3'd1;
    localparam logic [2:0] OP_FIRE_BLACK = 3'd2;
    localparam logic [2:0] OP_SELECT_ROW = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;

    // Nozzle limits
    localparam logic [8:0] COLOR_NOZZLE_MAX = 9'd224;
    localparam logic [9:0] BLACK_NOZZLES    = 10'd336;
    localparam logic [9:0] ROW_OFFSET       = 10'd168;
    localparam logic [1:0] COLOR_NONE       = 2'd3;
    localparam logic [9:0] NOZZLES_PER_GROUP = 10'd14;
    localparam logic [3:0] LAST_IN_GROUP    = 4'd13;
    localparam logic [3:0] FIRE_BIT_BASE    = 4'd13;

    // Divide by 14: multiply by reciprocal, exact for p below 680
    localparam logic [11:0] DIV14_MUL = 12'd2341;

    localparam logic [WORD_W-1:0] ROW_SET_MASK = 16'hE000;

    localparam logic [WORD_W-1:0] BLOCK_PATTERN [16] = '{
        16'hE000, 16'hE401, 16'hE420, 16'hE401, 16'hE008, 16'hE001, 16'hE002, 16'hE081,
        16'hE090, 16'hE084, 16'hE000, 16'hE040, 16'hE040, 16'hE040, 16'hE000, 16'hE000
    };

    localparam logic [WORD_W-1:0] TAIL_PATTERN [16] = '{
        16'hE400, 16'hE400, 16'hE400, 16'hE000, 16'hE400, 16'hE400, 16'hE400, 16'hE000,
        16'hE400, 16'hE400, 16'hE400, 16'hE000, 16'hE000, 16'hE400, 16'hE400, 16'hE400
    };

    localparam logic [3:0] COLOR_ORDER [3][14] = '{
        '{4'd8, 4'd13, 4'd4, 4'd9, 4'd0, 4'd5, 4'd10, 4'd1, 4'd6, 4'd11, 4'd2, 4'd7, 4'd12, 4'd3},
        '{4'd11, 4'd2, 4'd7, 4'd12, 4'd3, 4'd8, 4'd13, 4'd4, 4'd9, 4'd0, 4'd5, 4'd10, 4'd1, 4'd6},
        '{4'd0, 4'd5, 4'd10, 4'd1, 4'd6, 4'd11, 4'd2, 4'd7, 4'd12, 4'd3, 4'd8, 4'd13, 4'd4, 4'd9}
    };

    localparam logic [3:0] BLACK_ORDER [2][14] = '{
        '{4'd4, 4'd12, 4'd10, 4'd2, 4'd8, 4'd0, 4'd6, 4'd13, 4'd7, 4'd1, 4'd9, 4'd3, 4'd11, 4'd5},
        '{4'd13, 4'd7, 4'd1, 4'd9, 4'd3, 4'd11, 4'd5, 4'd4, 4'd12, 4'd10, 4'd2, 4'd8, 4'd0, 4'd6}
    };

    localparam logic [1:0] GROUP_LINE [24] = '{
        2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0,
        2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0
    };

    localparam logic [2:0] GROUP_BIT [24] = '{
        3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd4, 3'd5, 3'd4, 3'd5, 3'd4, 3'd5,
        3'd2, 3'd3, 3'd2, 3'd3, 3'd2, 3'd3, 3'd6, 3'd7, 3'd6, 3'd7, 3'd6, 3'd7
    };

    localparam logic GROUP_ORDER [24] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
    };

    // Decoded command handed from the mapper to the sequencer
    typedef struct packed {
        logic [2:0]        op;
        logic              err;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] clr_mask;
        logic [WORD_W-1:0] set_mask;
    } map_t;

    typedef struct packed {
        logic [5:0] q;
        logic [3:0] r;
    } div14_t;

    function automatic div14_t div14(input logic [9:0] p);
        logic [20:0] prod;
        div14_t      d;
        prod = 21'(p) * 21'(DIV14_MUL);
        d.q  = prod[20:15];
        d.r  = 4'(p - 10'(d.q) * NOZZLES_PER_GROUP);
        return d;
    endfunction

    function automatic logic [WORD_W-1:0] template_word(input logic [ADDR_W-1:0] idx);
        logic [WORD_W-1:0] w;
        if (idx < ADDR_W'(TAIL_START))
            w = BLOCK_PATTERN[idx[3:0]];
        else
            w = TAIL_PATTERN[idx[3:0]];
        return w;
    endfunction

endpackage

// ===== sv/inwb_if.sv =====
interface inwb_req_if;
    import inwb_pkg::*;

    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [8:0] nozzle;
    logic [1:0] ink_channel;
    logic       second_row;
    logic [ADDR_W-1:0] word_address;

    modport source (output valid, operation, nozzle, ink_channel, second_row, word_address,
                    input ready);
    modport sink   (input valid, operation, nozzle, ink_channel, second_row, word_address,
                    output ready);
endinterface

interface inwb_rsp_if;
    import inwb_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] read_data;
    logic              error;

    modport source (output valid, read_data, error, input ready);
    modport sink   (input valid, read_data, error, output ready);
endinterface

// ===== sv/inkjet_nozzle_waveform_buffer_core.sv =====
// Channel   Dir   Word
// req       in    operation, nozzle, ink_channel, second_row, word_address
// rsp       out   read_data, error
//
// Fire and read go from accept to result through decode, RAM read, write-back and post.
// Clear sweeps the 240-word RAM at one write per cycle.
// Select row reads and writes back 105 words through the single RAM read port.
// A rejected request goes straight from accept to posting its result, with no RAM access.
// Reset clears control only; the buffer holds no valid words until a clear.
// A held result does not block the next accept; a second result waits for the first.
module inkjet_nozzle_waveform_buffer_core (
    input logic        clk,
    input logic        rst_n,
    inwb_req_if.sink   req,
    inwb_rsp_if.source rsp
);
    import inwb_pkg::*;

    map_t cmd;

    inwb_map u_map (
        .operation    (req.operation),
        .nozzle       (req.nozzle),
        .ink_channel  (req.ink_channel),
        .second_row   (req.second_row),
        .word_address (req.word_address),
        .cmd          (cmd)
    );

    inwb_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .cmd_in    (cmd),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp.read_data),
        .rsp_error (rsp.error)
    );

endmodule

// ===== sv/inwb_ram.sv =====
module inwb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 240
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/inwb_map.sv =====
module inwb_map (
    input  logic [2:0]                 operation,
    input  logic [8:0]                 nozzle,
    input  logic [1:0]                 ink_channel,
    input  logic                       second_row,
    input  logic [inwb_pkg::ADDR_W-1:0] word_address,
    output inwb_pkg::map_t             cmd
);
    import inwb_pkg::*;

    logic [9:0]  p_black;
    logic [9:0]  p_sel;
    div14_t      d;
    logic        color_err;
    logic        black_err;
    logic [1:0]  color_idx;
    logic [4:0]  grp;
    logic [3:0]  color_ord;
    logic [3:0]  black_ord;
    logic [ADDR_W-1:0] color_addr;
    logic [ADDR_W-1:0] black_addr;
    logic [3:0]  black_bit;
    logic [3:0]  color_bit;

    // Form the linear nozzle index and split it into group and position
    assign p_black = {1'b0, nozzle} + (second_row ? ROW_OFFSET : 10'd0);
    assign p_sel   = (operation == OP_FIRE_BLACK) ? p_black : {1'b0, nozzle};
    assign d       = div14(p_sel);

    assign color_err = (nozzle > COLOR_NOZZLE_MAX) || (ink_channel == COLOR_NONE);
    assign black_err = (p_black >= BLACK_NOZZLES);

    // Keep table indexes legal on rejected requests
    assign color_idx = (ink_channel == COLOR_NONE) ? 2'd0 : ink_channel;
    assign grp       = black_err ? 5'd0 : d.q[4:0];

    // Color nozzle: word and bit
    assign color_ord  = COLOR_ORDER[color_idx][d.r];
    assign color_addr = {color_ord, 4'b0000} + ADDR_W'(d.q) + ADDR_W'(1);
    assign color_bit  = FIRE_BIT_BASE + 4'(color_idx);

    // Black nozzle: word and bit
    assign black_ord  = BLACK_ORDER[GROUP_ORDER[grp]][LAST_IN_GROUP - d.r];
    assign black_addr = {black_ord, 4'b0000} + ADDR_W'(1) + ADDR_W'(GROUP_BIT[grp]);
    assign black_bit  = FIRE_BIT_BASE + 4'(GROUP_LINE[grp]);

    // Decode the request
    always_comb
    begin
        cmd          = '0;
        cmd.op       = operation;
        case (operation)
            OP_CLEAR:
            begin
                cmd.err = 1'b0;
            end
            OP_FIRE_COLOR:
            begin
                cmd.err      = color_err;
                cmd.addr     = color_addr;
                cmd.clr_mask = WORD_W'(1) << color_bit;
            end
            OP_FIRE_BLACK:
            begin
                cmd.err      = black_err;
                cmd.addr     = black_addr;
                cmd.clr_mask = WORD_W'(1) << black_bit;
            end
            OP_SELECT_ROW:
            begin
                cmd.err      = 1'b0;
                cmd.set_mask = ROW_SET_MASK;
                cmd.clr_mask = WORD_W'(1) << {2'b11, ink_channel};
            end
            OP_READ:
            begin
                cmd.err  = (word_address >= ADDR_W'(BUFFER_WORDS));
                cmd.addr = word_address;
            end
            default:
            begin
                cmd.err = 1'b1;
            end
        endcase
    end

endmodule

// ===== sv/inwb_seq.sv =====
module inwb_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  inwb_pkg::map_t              cmd_in,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [inwb_pkg::WORD_W-1:0] rsp_data,
    output logic                        rsp_error
);
    import inwb_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_ROW    = 3'd2;
    localparam logic [2:0] ST_SINGLE = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    localparam logic [2:0] ROW_FIRST = 3'd1;
    localparam logic [2:0] ROW_LAST  = 3'd7;

    logic [2:0]        state_reg, state_next;
    map_t              cmd_reg, cmd_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [3:0]        blk_reg, blk_next;
    logic [2:0]        sub_reg, sub_next;
    logic              wb_valid_reg, wb_valid_next;
    logic [ADDR_W-1:0] wb_addr_reg, wb_addr_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_data_reg, out_data_next;
    logic              out_err_reg, out_err_next;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [ADDR_W-1:0] row_addr;

    inwb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BUFFER_WORDS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign row_addr = {blk_reg, 1'b0, sub_reg};

    // Write port: template sweep, else modified word from the previous read
    assign wr_en   = (state_reg == ST_CLEAR) || wb_valid_reg;
    assign wr_addr = (state_reg == ST_CLEAR) ? cnt_reg : wb_addr_reg;
    assign wr_data = (state_reg == ST_CLEAR) ? template_word(cnt_reg)
                                             : ((rd_data | cmd_reg.set_mask) & ~cmd_reg.clr_mask);

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;
    assign rsp_error = out_err_reg;

    // Sequence one word at a time
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cnt_next       = cnt_reg;
        blk_next       = blk_reg;
        sub_next       = sub_reg;
        wb_valid_next  = 1'b0;
        wb_addr_next   = wb_addr_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_data_next  = out_data_reg;
        out_err_next   = out_err_reg;
        rd_en          = 1'b0;
        rd_addr        = cmd_reg.addr;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next = cmd_in;
                    cnt_next = '0;
                    blk_next = '0;
                    sub_next = ROW_FIRST;
                    if (cmd_in.err)
                        state_next = ST_RESULT;
                    else if (cmd_in.op == OP_CLEAR)
                        state_next = ST_CLEAR;
                    else if (cmd_in.op == OP_SELECT_ROW)
                        state_next = ST_ROW;
                    else
                        state_next = ST_SINGLE;
                end
            end
            ST_CLEAR:
            begin
                if (cnt_reg == ADDR_W'(BUFFER_WORDS - 1))
                    state_next = ST_RESULT;
                else
                    cnt_next = cnt_reg + ADDR_W'(1);
            end
            ST_ROW:
            begin
                // Read one row word per cycle, write it back the next
                rd_en         = 1'b1;
                rd_addr       = row_addr;
                wb_valid_next = 1'b1;
                wb_addr_next  = row_addr;
                if (sub_reg == ROW_LAST)
                begin
                    sub_next = ROW_FIRST;
                    blk_next = blk_reg + 4'd1;
                    if (blk_reg == 4'(ROW_BLOCKS - 1))
                        state_next = ST_DRAIN;
                end
                else
                begin
                    sub_next = sub_reg + 3'd1;
                end
            end
            ST_SINGLE:
            begin
                rd_en         = 1'b1;
                wb_valid_next = (cmd_reg.op != OP_READ);
                wb_addr_next  = cmd_reg.addr;
                state_next    = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                // Post the word once the output register is free
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next = 1'b1;
                    out_err_next   = cmd_reg.err;
                    out_data_next  = (cmd_reg.op == OP_READ && !cmd_reg.err) ? rd_data : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wb_valid_reg  <= wb_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        cnt_reg      <= cnt_next;
        blk_reg      <= blk_next;
        sub_reg      <= sub_next;
        wb_addr_reg  <= wb_addr_next;
        out_data_reg <= out_data_next;
        out_err_reg  <= out_err_next;
    end

endmodule

// ===== sv/inwb_chk.sv =====
module inwb_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [inwb_pkg::WORD_W-1:0] rsp_read_data,
    input logic                        rsp_error
);
    import inwb_pkg::*;

    logic       req_acc;
    logic       rsp_acc;
    logic [1:0] pend_reg;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    // Track words accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else if (req_acc && !rsp_acc)
        begin
            pend_reg <= pend_reg + 2'd1;
        end
        else if (rsp_acc && !req_acc)
        begin
            pend_reg <= pend_reg - 2'd1;
        end
    end

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("result shown with no request outstanding");

    a_max_two: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two requests in flight");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> !req_ready)
        else $error("request taken while previous one still in work");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_error) |-> rsp_read_data == '0)
        else $error("rejected request returned nonzero data");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_read_data) && $stable(rsp_error)))
        else $error("stalled result changed");

endmodule

bind inkjet_nozzle_waveform_buffer_core inwb_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_read_data (rsp.read_data),
    .rsp_error     (rsp.error)
);

// ===== tb/inwb_waveform_checker.sv =====
`timescale 1ns / 1ps

module inwb_waveform_checker (
    input  logic clk,
    input  logic rst_n,
    inwb_req_if  req,
    inwb_rsp_if  rsp,
    output int   mismatches,
    output int   outstanding,
    output int   words_checked
);
    import inwb_pkg::*;

    // Buffer template and nozzle mapping tables
    localparam logic [15:0] TPL_BLOCK [16] = '{
        16'hE000, 16'hE401, 16'hE420, 16'hE401, 16'hE008, 16'hE001, 16'hE002, 16'hE081,
        16'hE090, 16'hE084, 16'hE000, 16'hE040, 16'hE040, 16'hE040, 16'hE000, 16'hE000
    };
    localparam logic [15:0] TPL_TAIL [16] = '{
        16'hE400, 16'hE400, 16'hE400, 16'hE000, 16'hE400, 16'hE400, 16'hE400, 16'hE000,
        16'hE400, 16'hE400, 16'hE400, 16'hE000, 16'hE000, 16'hE400, 16'hE400, 16'hE400
    };
    localparam int CLR_ORDER [3][14] = '{
        '{8, 13, 4, 9, 0, 5, 10, 1, 6, 11, 2, 7, 12, 3},
        '{11, 2, 7, 12, 3, 8, 13, 4, 9, 0, 5, 10, 1, 6},
        '{0, 5, 10, 1, 6, 11, 2, 7, 12, 3, 8, 13, 4, 9}
    };
    localparam int BLK_ORDER [2][14] = '{
        '{4, 12, 10, 2, 8, 0, 6, 13, 7, 1, 9, 3, 11, 5},
        '{13, 7, 1, 9, 3, 11, 5, 4, 12, 10, 2, 8, 0, 6}
    };
    localparam int GRP_LINE [24] = '{
        2, 2, 1, 1, 0, 0, 2, 2, 1, 1, 0, 0, 2, 2, 1, 1, 0, 0, 2, 2, 1, 1, 0, 0
    };
    localparam int GRP_BIT [24] = '{
        0, 1, 0, 1, 0, 1, 4, 5, 4, 5, 4, 5, 2, 3, 2, 3, 2, 3, 6, 7, 6, 7, 6, 7
    };
    localparam int GRP_ORDER [24] = '{
        1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    localparam int          COLOR_LAST_NOZZLE  = 224;
    localparam int          COLOR_LAST         = 2;
    localparam int          BLACK_NOZZLE_COUNT = 336;
    localparam int          ROW_SHIFT          = 168;
    localparam int          GROUP_SIZE         = 14;
    localparam int          FIRE_BIT0          = 13;
    localparam int          ROW_BIT0           = 12;
    localparam int          TAIL_WORDS         = 16;
    localparam logic [15:0] ROW_SET            = 16'hE000;
    localparam int          PRINT_CAP          = 40;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] data;
        logic        err;
    } owed_t;

    logic [15:0] wave_mem [BUFFER_WORDS];
    owed_t       owed_q [$];

    initial
    begin
        mismatches    = 0;
        outstanding   = 0;
        words_checked = 0;
        foreach (wave_mem[i])
            wave_mem[i] = '0;
    end

    task automatic report_mismatch(input string what);
        // keep the log short when the block is badly broken
        if (mismatches < PRINT_CAP)
            $display("%0t: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Apply one request to the buffer copy and return the word it owes
    function automatic owed_t apply_word(input logic [2:0] op, input logic [8:0] noz,
                                         input logic [1:0] ch, input logic row,
                                         input logic [7:0] addr);
        owed_t r;
        int    p;
        int    grp;
        int    idx;
        int    blk;
        int    slot;
        r.op   = op;
        r.data = '0;
        r.err  = 1'b0;
        case (op)
            OP_CLEAR:
            begin
                for (idx = 0; idx < BUFFER_WORDS; idx++)
                    wave_mem[idx] = (idx < BUFFER_WORDS - TAIL_WORDS) ? TPL_BLOCK[idx % 16]
                                                                      : TPL_TAIL[idx % 16];
            end
            OP_FIRE_COLOR:
            begin
                p = noz;
                if (p > COLOR_LAST_NOZZLE || ch > COLOR_LAST)
                    r.err = 1'b1;
                else
                begin
                    idx = 16 * CLR_ORDER[ch][p % GROUP_SIZE] + p / GROUP_SIZE + 1;
                    wave_mem[idx][FIRE_BIT0 + ch] = 1'b0;
                end
            end
            OP_FIRE_BLACK:
            begin
                p = noz + (row ? ROW_SHIFT : 0);
                if (p >= BLACK_NOZZLE_COUNT)
                    r.err = 1'b1;
                else
                begin
                    grp = p / GROUP_SIZE;
                    idx = 16 * BLK_ORDER[GRP_ORDER[grp]][GROUP_SIZE - 1 - p % GROUP_SIZE]
                          + 1 + GRP_BIT[grp];
                    wave_mem[idx][FIRE_BIT0 + GRP_LINE[grp]] = 1'b0;
                end
            end
            OP_SELECT_ROW:
            begin
                // words 1-7 of every 16-word block
                for (blk = 0; blk < BUFFER_WORDS - 9; blk += 16)
                    for (slot = 1; slot <= 7; slot++)
                    begin
                        idx = blk + slot;
                        wave_mem[idx] = wave_mem[idx] | ROW_SET;
                        wave_mem[idx][ROW_BIT0 + ch] = 1'b0;
                    end
            end
            OP_READ:
            begin
                if (addr < BUFFER_WORDS)
                    r.data = wave_mem[addr];
                else
                    r.err = 1'b1;
            end
            default:
                r.err = 1'b1;
        endcase
        return r;
    endfunction

    // Predict on every accepted request, compare on every accepted result
    always @(posedge clk)
    begin : watch
        owed_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                owed_q.push_back(apply_word(req.operation, req.nozzle, req.ink_channel,
                                            req.second_row, req.word_address));
            if (rsp.valid && rsp.ready)
            begin
                if (owed_q.size() == 0)
                    report_mismatch("result word arrived with nothing owed");
                else
                begin
                    want = owed_q.pop_front();
                    words_checked++;
                    if (rsp.read_data !== want.data)
                        report_mismatch($sformatf("op %0d read_data %h, want %h",
                                                  want.op, rsp.read_data, want.data));
                    if (rsp.error !== want.err)
                        report_mismatch($sformatf("op %0d error %b, want %b",
                                                  want.op, rsp.error, want.err));
                end
            end
            outstanding <= owed_q.size();
        end
    end

endmodule

// ===== tb/inkjet_nozzle_waveform_buffer_core_test.sv =====
`timescale 1ns / 1ps

module inkjet_nozzle_waveform_buffer_core_test;
    import inwb_pkg::*;

    localparam int         HALF_PERIOD  = 4;
    localparam int         RESET_CYCLES = 7;
    localparam int         RANDOM_WORDS = 1525;
    localparam int         QUIET_WORDS  = 150;
    localparam int         HOLD_AT      = 400;
    localparam int         HOLD_BURST   = 64;
    localparam int         PAUSE_AT     = 1000;
    localparam int         LONG_HOLD    = 250;
    localparam int         MAX_GAP      = 19;
    localparam int         DRAIN_CYCLES = 300;
    localparam int         CYCLE_LIMIT  = 2_000_000;
    localparam logic [2:0] OP_LAST_CODE = 3'd7;

    logic clk;
    logic rst_n;
    logic hold_rsp = 1'b0;
    logic quiet    = 1'b0;
    int   cycles   = 0;
    int   op_seen [8] = '{default: 0};
    int   mismatches;
    int   outstanding;
    int   words_checked;

    inwb_req_if req ();
    inwb_rsp_if rsp ();

    inkjet_nozzle_waveform_buffer_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    inwb_waveform_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .words_checked (words_checked)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL inkjet_nozzle_waveform_buffer_core");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold on request, none at the end
    initial
    begin : rsp_drain
        int run;
        rsp.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                hold_rsp = 1'b0;
                rsp.ready <= 1'b0;
                for (run = 0; run < LONG_HOLD; run++)
                    @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b0;
                run = $urandom_range(1, MAX_GAP);
                repeat (run) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                run = $urandom_range(1, 40);
                repeat (run) @(posedge clk);
            end
        end
    end

    // Offer one word and hold it until accepted
    task automatic offer_word(input logic [2:0] op, input logic [8:0] noz,
                              input logic [1:0] ch, input logic row,
                              input logic [7:0] addr);
        req.valid        <= 1'b1;
        req.operation    <= op;
        req.nozzle       <= noz;
        req.ink_channel  <= ch;
        req.second_row   <= row;
        req.word_address <= addr;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        op_seen[op]++;
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic drain_results();
        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic random_word();
        int         pick;
        logic [2:0] op;
        logic [8:0] noz;
        logic [1:0] ch;
        logic       row;
        logic [7:0] addr;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            op = OP_CLEAR;
        else if (pick < 32)
            op = OP_FIRE_COLOR;
        else if (pick < 60)
            op = OP_FIRE_BLACK;
        else if (pick < 64)
            op = OP_SELECT_ROW;
        else if (pick < 95)
            op = OP_READ;
        else
            op = 3'($urandom_range(OP_READ + 1, OP_LAST_CODE));
        row  = 1'($urandom_range(0, 1));
        ch   = 2'($urandom_range(0, 3));
        noz  = 9'($urandom);
        addr = 8'($urandom);
        // keep most requests in range so they land in the buffer
        if ($urandom_range(0, 9) != 0)
        begin
            if (op == OP_FIRE_COLOR)
            begin
                ch  = 2'($urandom_range(0, 2));
                noz = 9'($urandom_range(0, 224));
            end
            else if (op == OP_FIRE_BLACK)
                noz = 9'($urandom_range(0, row ? 167 : 335));
            addr = 8'($urandom_range(0, BUFFER_WORDS - 1));
        end
        offer_word(op, noz, ch, row, addr);
    endtask

    initial
    begin : stimulus
        int n;
        int gap_free_until;
        rst_n            <= 1'b0;
        req.valid        <= 1'b0;
        req.operation    <= OP_READ;
        req.nozzle       <= '0;
        req.ink_channel  <= '0;
        req.second_row   <= 1'b0;
        req.word_address <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: load the template first so no read sees an unwritten word
        offer_word(OP_CLEAR,      9'd0,   2'd0, 1'b0, 8'd0);
        offer_word(OP_READ,       9'd511, 2'd3, 1'b1, 8'd0);
        offer_word(OP_READ,       9'd0,   2'd0, 1'b0, 8'd239);
        offer_word(OP_READ,       9'd0,   2'd0, 1'b0, 8'd240);
        offer_word(OP_READ,       9'd0,   2'd0, 1'b0, 8'd255);
        offer_word(OP_FIRE_COLOR, 9'd0,   2'd0, 1'b1, 8'd255);
        offer_word(OP_FIRE_COLOR, 9'd224, 2'd2, 1'b0, 8'd0);
        offer_word(OP_FIRE_COLOR, 9'd225, 2'd1, 1'b0, 8'd0);
        offer_word(OP_FIRE_COLOR, 9'd100, 2'd3, 1'b0, 8'd0);
        offer_word(OP_FIRE_COLOR, 9'd511, 2'd0, 1'b0, 8'd0);
        offer_word(OP_READ,       9'd0,   2'd0, 1'b0, 8'd129);
        offer_word(OP_READ,       9'd0,   2'd0, 1'b0, 8'd17);
        offer_word(OP_FIRE_BLACK, 9'd0,   2'd3, 1'b0, 8'd255);
        offer_word(OP_FIRE_BLACK, 9'd335, 2'd0, 1'b0, 8'd0);
        offer_word(OP_FIRE_BLACK, 9'd0,   2'd0, 1'b1, 8'd0);
        offer_word(OP_FIRE_BLACK, 9'd167, 2'd0, 1'b1, 8'd0);
        offer_word(OP_FIRE_BLACK, 9'd168, 2'd0, 1'b1, 8'd0);
        offer_word(OP_SELECT_ROW, 9'd0,   2'd0, 1'b0, 8'd0);
        offer_word(OP_READ,       9'd0,   2'd0, 1'b0, 8'd1);
        offer_word(OP_SELECT_ROW, 9'd511, 2'd3, 1'b1, 8'd255);
        offer_word(OP_READ,       9'd0,   2'd0, 1'b0, 8'd7);
        offer_word(OP_SELECT_ROW, 9'd0,   2'd1, 1'b0, 8'd0);
        offer_word(OP_SELECT_ROW, 9'd0,   2'd2, 1'b0, 8'd0);
        offer_word(OP_READ + 3'd1, 9'd0,  2'd0, 1'b0, 8'd0);
        offer_word(OP_LAST_CODE,  9'd511, 2'd3, 1'b1, 8'd255);
        drain_results();

        // Random traffic with a long result hold and a full drain partway
        gap_free_until = 0;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == HOLD_AT)
            begin
                hold_rsp       = 1'b1;
                gap_free_until = n + HOLD_BURST;
            end
            if (n == PAUSE_AT)
                drain_results();
            if (n == RANDOM_WORDS - QUIET_WORDS)
                quiet = 1'b1;
            if (!quiet && n >= gap_free_until && $urandom_range(0, 5) == 0)
            begin
                req.valid <= 1'b0;
                repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
            end
            random_word();
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d requests: %0d clear, %0d color fire, %0d black fire, %0d row select,",
                 op_seen.sum(), op_seen[OP_CLEAR], op_seen[OP_FIRE_COLOR],
                 op_seen[OP_FIRE_BLACK], op_seen[OP_SELECT_ROW]);
        $display("%0d read, %0d unused code; %0d result words checked, %0d mismatches",
                 op_seen[OP_READ], op_seen[5] + op_seen[6] + op_seen[OP_LAST_CODE],
                 words_checked, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS inkjet_nozzle_waveform_buffer_core");
        else
            $display("FAIL inkjet_nozzle_waveform_buffer_core");
        $finish;
    end

endmodule
